// ===== rtl/bgva_pkg.sv =====
// ----------------------------------------------------------------------------
// bgva_pkg: shared types and constants for the bilateral-grid vertex assigner
// Beat payloads, configuration register codes, slot memory entry layout,
// key weights and the multiplicative hash constant.
// ----------------------------------------------------------------------------
package bgva_pkg;

  // Field widths fixed by the pixel and vertex formats
  localparam int COORD_W   = 12;
  localparam int BYTE_W    = 8;
  localparam int SCALE_W   = 17;
  localparam int KEY_W     = 48;
  localparam int ID_W      = 16;
  localparam int COUNT_W   = 17;
  localparam int EPOCH_W   = 8;
  localparam int CFG_IDX_W = 2;

  // Quantized coordinate widths: floor(value * scale / 65536)
  localparam int QX_W = COORD_W + SCALE_W - 16;  // 13
  localparam int QB_W = BYTE_W + SCALE_W - 16;   // 9
  localparam int PART_LO_W = 26;

  // Configuration register codes
  localparam logic [CFG_IDX_W-1:0] REG_SPATIAL_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LUMA_SCALE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHROMA_SCALE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOUR_MODE   = 2'd3;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 17'd8192;

  // Vertex numbering limit
  localparam logic [COUNT_W-1:0] VERTEX_LIMIT = 17'd65536;

  // Epoch marks: zero means free, live images run from EPOCH_FIRST to EPOCH_LAST
  localparam logic [EPOCH_W-1:0] EPOCH_FREE  = 8'd0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'd255;

  // Key weights: powers of 255
  localparam logic [PART_LO_W-1:0] W_Y    = 26'd255;
  localparam logic [PART_LO_W-1:0] W_LUMA = 26'd65025;
  localparam logic [KEY_W-1:0]     W_CR   = 48'd16581375;
  localparam logic [KEY_W-1:0]     W_CB   = 48'd4228250625;

  // Multiplicative hash constant, split into 32-bit halves
  localparam logic [31:0] HASH_LO = 32'h7F4A7C15;
  localparam logic [31:0] HASH_HI = 32'h9E3779B9;

  typedef struct packed {
    logic               first_pixel;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row_index;
    logic [BYTE_W-1:0]  luma;
    logic [BYTE_W-1:0]  chroma_red;
    logic [BYTE_W-1:0]  chroma_blue;
  } pixel_t;

  typedef struct packed {
    logic [ID_W-1:0]    vertex_id;
    logic               new_vertex;
    logic               table_full;
    logic [COUNT_W-1:0] vertex_count;
  } vertex_t;

  // One slot of the hash table
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [KEY_W-1:0]   key;
    logic [ID_W-1:0]    id;
  } slot_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_QUANT,
    S_KEY_PART,
    S_KEY_SUM,
    S_HASH,
    S_MIX,
    S_HOME,
    S_WIPE,
    S_READ,
    S_CHECK,
    S_EMIT
  } state_t;

endpackage

// ===== rtl/bilateral_grid_vertex_assign.sv =====
// ----------------------------------------------------------------------------
// bilateral_grid_vertex_assign: grid vertex numbering for a bilateral-grid splat
// Quantizes each guide pixel onto the grid, hashes the grid key and looks it up
// in a linear-probing table held in one synchronous slot memory.
//
//   channel   dir   handshake               payload
//   pixel     in    pixel_valid/stall       bgva_pkg::pixel_t
//   vertex    out   vertex_valid/stall      bgva_pkg::vertex_t
//   cfg       in    cfg_write               cfg_index, cfg_data
//
// Each pixel passes through the quantize, key, hash and home steps and then P
// (1..MAX_PROBES) slot probes, one per cycle through the single read port of the
// slot memory, before its result is emitted; no new pixel is taken until then.
// After reset a sweep marks every slot free before the first pixel is taken; the
// same sweep runs once every 255 images, when the epoch mark wraps. A stalled
// result waits in the output register while the next pixel is already taken.
// TABLE_SLOTS must be a power of two.
// ----------------------------------------------------------------------------
module bilateral_grid_vertex_assign #(
  parameter int TABLE_SLOTS = 65536,
  parameter int MAX_PROBES  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pixel_valid,
  output logic                                pixel_stall,
  input  bgva_pkg::pixel_t                    pixel,
  output logic                                vertex_valid,
  input  logic                                vertex_stall,
  output bgva_pkg::vertex_t                   vertex,
  input  logic                                cfg_write,
  input  logic [bgva_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bgva_pkg::SCALE_W-1:0]        cfg_data
);
  import bgva_pkg::*;

  localparam int IDX_W   = $clog2(TABLE_SLOTS);
  localparam int PROBE_W = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
  localparam logic [PROBE_W-1:0] PROBE_LAST = PROBE_W'(MAX_PROBES - 1);
  localparam logic [IDX_W-1:0]   PTR_LAST   = {IDX_W{1'b1}};

  // Configuration registers
  logic [SCALE_W-1:0] spatial_scale;
  logic [SCALE_W-1:0] luma_scale;
  logic [SCALE_W-1:0] chroma_scale;
  logic               colour_mode;

  // Control state
  state_t             state;
  state_t             state_next;
  logic [EPOCH_W-1:0] epoch;
  logic               wipe_pending;
  logic [IDX_W-1:0]   wipe_ptr;
  logic [IDX_W-1:0]   probe_addr;
  logic [PROBE_W-1:0] probe_cnt;
  logic [COUNT_W-1:0] vertex_counter;

  // Datapath registers
  pixel_t               item;
  logic [QX_W-1:0]      cx;
  logic [QX_W-1:0]      cy;
  logic [QB_W-1:0]      cl;
  logic [QB_W-1:0]      cr;
  logic [QB_W-1:0]      cb;
  logic [PART_LO_W-1:0] part_lo;
  logic [KEY_W-1:0]     part_hi;
  logic [KEY_W-1:0]     key;
  logic [55:0]          pp0;
  logic [55:0]          pp1;
  logic [55:0]          pp2;
  logic [7:0]           pp3;
  logic [63:0]          mix_a;
  logic [63:0]          mix_b;
  vertex_t              res;

  // Slot memory
  slot_t            slot_mem [TABLE_SLOTS];
  slot_t            rd_slot;
  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  slot_t            mem_wr_data;

  // Combinational helpers
  logic                     pixel_accept;
  logic                     out_free;
  logic [COORD_W+SCALE_W-1:0] prod_x;
  logic [COORD_W+SCALE_W-1:0] prod_y;
  logic [BYTE_W+SCALE_W-1:0]  prod_l;
  logic [BYTE_W+SCALE_W-1:0]  prod_r;
  logic [BYTE_W+SCALE_W-1:0]  prod_b;
  logic [63:0]              mixed;
  logic                     slot_free;
  logic                     key_hit;
  logic                     room;
  logic                     last_probe;
  logic [IDX_W-1:0]         probe_addr_inc;

  assign pixel_stall  = (state != S_IDLE);
  assign pixel_accept = pixel_valid && !pixel_stall;
  assign out_free     = !vertex_valid || !vertex_stall;

  assign prod_x = (COORD_W+SCALE_W)'(item.column) * (COORD_W+SCALE_W)'(spatial_scale);
  assign prod_y = (COORD_W+SCALE_W)'(item.row_index) * (COORD_W+SCALE_W)'(spatial_scale);
  assign prod_l = (BYTE_W+SCALE_W)'(item.luma) * (BYTE_W+SCALE_W)'(luma_scale);
  assign prod_r = (BYTE_W+SCALE_W)'(item.chroma_red) * (BYTE_W+SCALE_W)'(chroma_scale);
  assign prod_b = (BYTE_W+SCALE_W)'(item.chroma_blue) * (BYTE_W+SCALE_W)'(chroma_scale);

  assign mixed = mix_a + mix_b;

  assign slot_free      = (rd_slot.epoch != epoch);
  assign key_hit        = !slot_free && (rd_slot.key == key);
  assign room           = (vertex_counter != VERTEX_LIMIT);
  assign last_probe     = (probe_cnt == PROBE_LAST);
  assign probe_addr_inc = probe_addr + IDX_W'(1);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      spatial_scale <= SCALE_RESET;
      luma_scale    <= SCALE_RESET;
      chroma_scale  <= SCALE_RESET;
      colour_mode   <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SPATIAL_SCALE: spatial_scale <= cfg_data;
        REG_LUMA_SCALE:    luma_scale    <= cfg_data;
        REG_CHROMA_SCALE:  chroma_scale  <= cfg_data;
        REG_COLOUR_MODE:   colour_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory control
  always_comb begin
    state_next  = state;
    mem_rd_en   = 1'b0;
    mem_rd_addr = probe_addr;
    mem_wr_en   = 1'b0;
    mem_wr_addr = probe_addr;
    mem_wr_data = '{epoch: epoch, key: key, id: vertex_counter[ID_W-1:0]};
    case (state)
      S_INIT, S_WIPE: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = wipe_ptr;
        mem_wr_data = '{epoch: EPOCH_FREE, key: '0, id: '0};
        if (wipe_ptr == PTR_LAST) begin
          state_next = (state == S_INIT) ? S_IDLE : S_READ;
        end
      end
      S_IDLE: begin
        if (pixel_accept) begin
          state_next = S_QUANT;
        end
      end
      S_QUANT:    state_next = S_KEY_PART;
      S_KEY_PART: state_next = S_KEY_SUM;
      S_KEY_SUM:  state_next = S_HASH;
      S_HASH:     state_next = S_MIX;
      S_MIX:      state_next = S_HOME;
      S_HOME: begin
        state_next = wipe_pending ? S_WIPE : S_READ;
      end
      S_READ: begin
        mem_rd_en  = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (slot_free) begin
          mem_wr_en  = room;
          state_next = S_EMIT;
        end else if (key_hit || last_probe) begin
          state_next = S_EMIT;
        end else begin
          // miss: read the next slot, one probe per cycle
          mem_rd_en   = 1'b1;
          mem_rd_addr = probe_addr_inc;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      slot_mem[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      rd_slot <= slot_mem[mem_rd_addr];
    end
  end

  // Advance the sweep pointer; it wraps back to zero at the end of a sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      wipe_ptr <= '0;
    end else if (state == S_INIT || state == S_WIPE) begin
      wipe_ptr <= wipe_ptr + IDX_W'(1);
    end
  end

  // Epoch mark: a first pixel opens a new image; wrap forces a sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      epoch        <= EPOCH_FIRST;
      wipe_pending <= 1'b0;
    end else if (pixel_accept && pixel.first_pixel) begin
      if (epoch == EPOCH_LAST) begin
        epoch        <= EPOCH_FIRST;
        wipe_pending <= 1'b1;
      end else begin
        epoch <= epoch + EPOCH_W'(1);
      end
    end else if (state == S_WIPE && wipe_ptr == PTR_LAST) begin
      wipe_pending <= 1'b0;
    end
  end

  // Vertex counter: clear on a first pixel, bump on each new vertex
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_counter <= '0;
    end else if (pixel_accept && pixel.first_pixel) begin
      vertex_counter <= '0;
    end else if (state == S_CHECK && slot_free && room) begin
      vertex_counter <= vertex_counter + COUNT_W'(1);
    end
  end

  // Capture the pixel beat
  always_ff @(posedge clk) begin
    if (pixel_accept) begin
      item <= pixel;
    end
  end

  // Quantize, build the key and hash it, one step per state
  always_ff @(posedge clk) begin
    case (state)
      S_QUANT: begin
        cx <= prod_x[COORD_W+SCALE_W-1:16];
        cy <= prod_y[COORD_W+SCALE_W-1:16];
        cl <= prod_l[BYTE_W+SCALE_W-1:16];
        cr <= prod_r[BYTE_W+SCALE_W-1:16];
        cb <= prod_b[BYTE_W+SCALE_W-1:16];
      end
      S_KEY_PART: begin
        part_lo <= PART_LO_W'(cx) + PART_LO_W'(cy) * W_Y + PART_LO_W'(cl) * W_LUMA;
        if (colour_mode) begin
          part_hi <= KEY_W'(cr) * W_CR + KEY_W'(cb) * W_CB;
        end else begin
          part_hi <= '0;
        end
      end
      S_KEY_SUM: begin
        key <= KEY_W'(part_lo) + part_hi;
      end
      S_HASH: begin
        // low 64 bits of key times the hash constant, as three 24x32 and one 8x8 partial products
        pp0 <= {32'b0, key[23:0]} * {24'b0, HASH_LO};
        pp1 <= {32'b0, key[47:24]} * {24'b0, HASH_LO};
        pp2 <= {32'b0, key[23:0]} * {24'b0, HASH_HI};
        pp3 <= key[31:24] * HASH_HI[7:0];
      end
      S_MIX: begin
        mix_a <= {8'b0, pp0} + {pp1[39:0], 24'b0};
        mix_b <= {pp2[31:0], 32'b0} + {pp3, 56'b0};
      end
      default: ;
    endcase
  end

  // Probe address and probe count
  always_ff @(posedge clk) begin
    if (state == S_HOME) begin
      probe_addr <= mixed[32 +: IDX_W];
      probe_cnt  <= '0;
    end else if (state == S_CHECK && !slot_free && !key_hit && !last_probe) begin
      probe_addr <= probe_addr_inc;
      probe_cnt  <= probe_cnt + PROBE_W'(1);
    end
  end

  // Form the result of the lookup
  always_ff @(posedge clk) begin
    if (state == S_CHECK) begin
      if (slot_free && room) begin
        res <= '{vertex_id: vertex_counter[ID_W-1:0], new_vertex: 1'b1,
                 table_full: 1'b0, vertex_count: vertex_counter + COUNT_W'(1)};
      end else if (key_hit) begin
        res <= '{vertex_id: rd_slot.id, new_vertex: 1'b0,
                 table_full: 1'b0, vertex_count: vertex_counter};
      end else begin
        res <= '{vertex_id: '0, new_vertex: 1'b0,
                 table_full: 1'b1, vertex_count: vertex_counter};
      end
    end
  end

  // Output register: load the result when the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      vertex_valid <= 1'b1;
    end else if (!vertex_stall) begin
      vertex_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      vertex <= res;
    end
  end

  // A new-vertex write bumps the counter by exactly one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && mem_wr_en) |=> vertex_counter == $past(vertex_counter) + COUNT_W'(1))
    else $error("vertex counter out of step with slot write");

  // A created vertex never reports a full table
  a_new_not_full: assert property (@(posedge clk) disable iff (rst)
    vertex_valid |-> !(vertex.new_vertex && vertex.table_full))
    else $error("new vertex flagged with full table");

  // A new vertex's number is one less than the count after it
  a_new_id: assert property (@(posedge clk) disable iff (rst)
    (vertex_valid && vertex.new_vertex) |->
      vertex.vertex_count == {1'b0, vertex.vertex_id} + COUNT_W'(1))
    else $error("new vertex number does not match count");

  // Probing never starts while a sweep is still owed
  a_no_probe_before_wipe: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> !wipe_pending)
    else $error("probe started before slot sweep");

  // The live epoch is never the free mark
  a_epoch_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> epoch != EPOCH_FREE)
    else $error("live epoch equals free mark");

endmodule
